>>> hw/rtl/nmea_sentence_filter_checker_defines.svh
// assertion macros for the nmea sentence filter checker
// used by the modules that carry concurrent assertions, no other dependencies
`ifndef NMEA_SENTENCE_FILTER_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_FILTER_CHECKER_DEFINES_SVH

// same-cycle implication
`define NSFC_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NSFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/nsfc_pkg.sv
// shared types, character codes and lookup functions for the nmea sentence filter checker
// no dependencies
`default_nettype none

package nsfc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam int NUM_NAMES = 3;
    localparam int NAME_LEN  = 5;
    localparam int LEN_W     = 7;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        KIND_GNRMC = 2'd0,
        KIND_GPGSA = 2'd1,
        KIND_GNGGA = 2'd2
    } kind_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_beat_t;

    typedef struct packed {
        kind_t             sentence_type;
        logic              checksum_ok;
        logic [LEN_W-1:0]  sentence_length;
    } result_t;

    // expected character of name k at name index idx (0 to 4)
    function automatic logic [7:0] name_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case ({k, idx})
            {KIND_GNRMC, 3'd0}: c = "G";
            {KIND_GNRMC, 3'd1}: c = "N";
            {KIND_GNRMC, 3'd2}: c = "R";
            {KIND_GNRMC, 3'd3}: c = "M";
            {KIND_GNRMC, 3'd4}: c = "C";
            {KIND_GPGSA, 3'd0}: c = "G";
            {KIND_GPGSA, 3'd1}: c = "P";
            {KIND_GPGSA, 3'd2}: c = "G";
            {KIND_GPGSA, 3'd3}: c = "S";
            {KIND_GPGSA, 3'd4}: c = "A";
            {KIND_GNGGA, 3'd0}: c = "G";
            {KIND_GNGGA, 3'd1}: c = "N";
            {KIND_GNGGA, 3'd2}: c = "G";
            {KIND_GNGGA, 3'd3}: c = "G";
            {KIND_GNGGA, 3'd4}: c = "A";
            default:            c = 8'h00;
        endcase
        return c;
    endfunction

    // hex digit value, all ones (-1) for anything that is not a hex digit
    function automatic logic signed [4:0] hex_value(input logic [7:0] b);
        logic signed [4:0] v;
        v = 5'sh1F;
        if (b >= "0" && b <= "9") begin
            v = 5'(b - 8'h30);
        end
        else if (b >= "A" && b <= "F") begin
            v = 5'(b - 8'h37);
        end
        else if (b >= "a" && b <= "f") begin
            v = 5'(b - 8'h57);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nsfc_in_stage.sv
// input register for received bytes with stream handshake
// depends on nsfc_pkg
`default_nettype none

module nsfc_in_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] rx_byte
    input  wire logic               advance,
    output nsfc_pkg::byte_beat_t    beat
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = byte_reg;

endmodule

`default_nettype wire

>>> hw/rtl/nsfc_tracker.sv
// sentence state, name filter and checksum check, one byte per cycle while advance is high
// depends on nsfc_pkg and nmea_sentence_filter_checker_defines.svh
`default_nettype none
`include "nmea_sentence_filter_checker_defines.svh"

module nsfc_tracker #(
    parameter int MAX_LEN = 128
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nsfc_pkg::byte_beat_t beat,
    input  wire logic               advance,
    output logic                    res_valid,
    output nsfc_pkg::result_t       res
);

    localparam int PW = $clog2(MAX_LEN);
    localparam logic [PW-1:0] LAST_POS = PW'(MAX_LEN - 1);
    localparam logic [PW-1:0] MIN_POS  = PW'(6);

    logic                    step;
    logic [7:0]              b;

    logic                    collecting_reg, collecting_next;
    logic [PW-1:0]           position_reg, position_next;
    logic [2:0]              name_match_reg, name_match_next;
    nsfc_pkg::kind_t         kind_reg, kind_next;
    logic [7:0]              xor_reg, xor_next;
    logic                    star_reg, star_next;
    logic                    zero_reg, zero_next;
    logic [1:0]              digits_reg, digits_next;
    logic signed [4:0]       hi_reg, hi_next;
    logic signed [4:0]       lo_reg, lo_next;

    logic                    emit;
    logic [9:0]              cs_value;

    assign step = beat.valid && advance;
    assign b    = beat.data;

    always_comb
    begin
        collecting_next = collecting_reg;
        position_next   = position_reg;
        name_match_next = name_match_reg;
        kind_next       = kind_reg;
        xor_next        = xor_reg;
        star_next       = star_reg;
        zero_next       = zero_reg;
        digits_next     = digits_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        emit            = 1'b0;

        if (b == nsfc_pkg::CH_DOLLAR) begin
            collecting_next = 1'b1;
            position_next   = '0;
            name_match_next = 3'b111;
            kind_next       = nsfc_pkg::KIND_GNRMC;
            xor_next        = '0;
            star_next       = 1'b0;
            zero_next       = 1'b0;
            digits_next     = '0;
            hi_next         = 5'sh1F;
            lo_next         = 5'sh1F;
        end

        if (collecting_next) begin
            if (position_next >= PW'(1) && position_next <= PW'(5)) begin
                for (int k = 0; k < nsfc_pkg::NUM_NAMES; k++) begin
                    if (nsfc_pkg::name_char(2'(k), 3'(position_next[2:0] - 3'd1)) != b) begin
                        name_match_next[k] = 1'b0;
                    end
                end
            end

            if (position_next == PW'(5) && name_match_next == 3'b000) begin
                collecting_next = 1'b0;
            end
            else begin
                if (position_next == PW'(5)) begin
                    if (name_match_next[0]) begin
                        kind_next = nsfc_pkg::KIND_GNRMC;
                    end
                    else if (name_match_next[1]) begin
                        kind_next = nsfc_pkg::KIND_GPGSA;
                    end
                    else begin
                        kind_next = nsfc_pkg::KIND_GNGGA;
                    end
                end

                if (position_next >= LAST_POS) begin
                    collecting_next = 1'b0;
                end
                else if (b == nsfc_pkg::CH_CR) begin
                    collecting_next = 1'b0;
                    emit            = position_next >= MIN_POS;
                end
                else begin
                    if (position_next >= PW'(1)) begin
                        if (!star_next) begin
                            if (!zero_next) begin
                                if (b == nsfc_pkg::CH_STAR) begin
                                    star_next = 1'b1;
                                end
                                else if (b == nsfc_pkg::CH_NUL) begin
                                    zero_next = 1'b1;
                                end
                                else begin
                                    xor_next = xor_next ^ b;
                                end
                            end
                        end
                        else if (digits_next < 2'd2) begin
                            if (digits_next == 2'd0) begin
                                hi_next = nsfc_pkg::hex_value(b);
                            end
                            else begin
                                lo_next = nsfc_pkg::hex_value(b);
                            end
                            digits_next = digits_next + 2'd1;
                        end
                    end
                    position_next = position_next + PW'(1);
                end
            end
        end
    end

    // hi*16 + lo in ten bit two's complement
    assign cs_value = {hi_reg[4], hi_reg, 4'b0000} + {{5{lo_reg[4]}}, lo_reg};

    assign res_valid           = step && emit;
    assign res.sentence_type   = kind_next;
    assign res.checksum_ok     = star_reg && (cs_value == {2'b00, xor_reg});
    assign res.sentence_length = nsfc_pkg::LEN_W'(position_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            collecting_reg <= 1'b0;
            position_reg   <= '0;
            name_match_reg <= 3'b111;
            kind_reg       <= nsfc_pkg::KIND_GNRMC;
            xor_reg        <= '0;
            star_reg       <= 1'b0;
            zero_reg       <= 1'b0;
            digits_reg     <= '0;
            hi_reg         <= 5'sh1F;
            lo_reg         <= 5'sh1F;
        end
        else if (step) begin
            collecting_reg <= collecting_next;
            position_reg   <= position_next;
            name_match_reg <= name_match_next;
            kind_reg       <= kind_next;
            xor_reg        <= xor_next;
            star_reg       <= star_next;
            zero_reg       <= zero_next;
            digits_reg     <= digits_next;
            hi_reg         <= hi_next;
            lo_reg         <= lo_next;
        end
    end

    `NSFC_ASSERT_HOLDS(a_emit_needs_sentence, clk, rst_n, res_valid, collecting_reg && position_reg >= MIN_POS, "result without a named sentence")
    `NSFC_ASSERT_HOLDS(a_star_excludes_zero, clk, rst_n, star_reg, !zero_reg, "star and zero byte both seen")
    `NSFC_ASSERT_HOLDS(a_digits_after_star, clk, rst_n, digits_reg != 2'd0, star_reg && digits_reg != 2'd3, "digit taken without star")
    `NSFC_ASSERT_HOLDS(a_named_past_five, clk, rst_n, collecting_reg && position_reg > PW'(5), name_match_reg != 3'b000, "collecting with no name match")

endmodule

`default_nettype wire

>>> hw/rtl/nsfc_out_stage.sv
// result register driving the master side of the stream
// depends on nsfc_pkg
`default_nettype none

module nsfc_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_valid,
    input  wire nsfc_pkg::result_t  res,
    output logic                    advance,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [nsfc_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic               valid_reg;
    logic               valid_next;
    nsfc_pkg::result_t  res_reg;

    assign advance = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b000000, res_reg.sentence_length, res_reg.checksum_ok,
                       res_reg.sentence_type};

endmodule

`default_nettype wire

>>> hw/rtl/nmea_sentence_filter_checker.sv
// nmea sentence filter checker: a byte is registered in the input stage, and its result beat in the output stage
// throughput one byte per cycle while the result side does not stall, set by the single-pass byte update in the tracker
// one result beat per accepted carriage return that closes a named sentence
// rst_n clears all sentence state and both stage valids asynchronously
// depends on nsfc_pkg, nsfc_in_stage, nsfc_tracker, nsfc_out_stage
`default_nettype none

module nmea_sentence_filter_checker #(
    parameter int MAX_LEN = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [1:0] sentence_type, [2] checksum_ok, [9:3] sentence_length
);

    nsfc_pkg::byte_beat_t beat;
    nsfc_pkg::result_t    res;
    logic                 res_valid;
    logic                 advance;

    nsfc_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .beat     (beat)
    );

    nsfc_tracker #(
        .MAX_LEN (MAX_LEN)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    nsfc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

>>> tb/sentence_result_monitor.sv
// sentence result monitor: watches the byte and result streams of the nmea sentence filter
// checker, tracks each sentence byte by byte, and compares every result beat with its prediction
// depends on nsfc_pkg
module sentence_result_monitor #(
    parameter int MAX_LEN = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          error_count,
    output int          pending
);

    localparam logic [39:0] TEXT_GNRMC = "GNRMC";
    localparam logic [39:0] TEXT_GPGSA = "GPGSA";
    localparam logic [39:0] TEXT_GNGGA = "GNGGA";

    nsfc_pkg::result_t sentence_reports_q [$];

    bit               in_sentence;
    int               byte_index;
    logic [2:0]       name_hits;
    nsfc_pkg::kind_t  name_kind;
    logic [7:0]       body_xor;
    bit               star_found;
    bit               nul_found;
    int               digit_count;
    int               digit_hi;
    int               digit_lo;

    function automatic logic [7:0] name_letter(input int k, input int i);
        logic [39:0] word;
        case (k)
            0:       word = TEXT_GNRMC;
            1:       word = TEXT_GPGSA;
            default: word = TEXT_GNGGA;
        endcase
        return word[39 - 8 * i -: 8];
    endfunction

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b) - 48;
        if (b >= "A" && b <= "F")
            return int'(b) - 55;
        if (b >= "a" && b <= "f")
            return int'(b) - 87;
        return -1;
    endfunction

    task automatic restart_sentence();
        byte_index  = 0;
        name_hits   = 3'b111;
        name_kind   = nsfc_pkg::KIND_GNRMC;
        body_xor    = 8'h00;
        star_found  = 0;
        nul_found   = 0;
        digit_count = 0;
        digit_hi    = -1;
        digit_lo    = -1;
    endtask

    task automatic track_rx_byte(input logic [7:0] b);
        nsfc_pkg::result_t r;
        int                k;
        if (b == nsfc_pkg::CH_DOLLAR) begin
            restart_sentence();
            in_sentence = 1;
        end
        if (!in_sentence)
            return;
        if (byte_index >= 1 && byte_index <= nsfc_pkg::NAME_LEN) begin
            for (k = 0; k < nsfc_pkg::NUM_NAMES; k++)
                if (name_letter(k, byte_index - 1) != b)
                    name_hits[k] = 1'b0;
            if (byte_index == nsfc_pkg::NAME_LEN) begin
                if (name_hits[0])
                    name_kind = nsfc_pkg::KIND_GNRMC;
                else if (name_hits[1])
                    name_kind = nsfc_pkg::KIND_GPGSA;
                else if (name_hits[2])
                    name_kind = nsfc_pkg::KIND_GNGGA;
                else begin
                    in_sentence = 0;
                    return;
                end
            end
        end
        if (byte_index >= MAX_LEN - 1) begin
            in_sentence = 0;
            return;
        end
        if (b == nsfc_pkg::CH_CR) begin
            in_sentence = 0;
            if (byte_index < 6)
                return;
            r.sentence_type   = name_kind;
            r.checksum_ok     = star_found && (digit_hi * 16 + digit_lo == int'(body_xor));
            r.sentence_length = byte_index[nsfc_pkg::LEN_W-1:0];
            sentence_reports_q.push_back(r);
            return;
        end
        if (byte_index >= 1) begin
            if (!star_found) begin
                if (!nul_found) begin
                    if (b == nsfc_pkg::CH_STAR)
                        star_found = 1;
                    else if (b == nsfc_pkg::CH_NUL)
                        nul_found = 1;
                    else
                        body_xor ^= b;
                end
            end
            else if (digit_count < 2) begin
                if (digit_count == 0)
                    digit_hi = hex_digit(b);
                else
                    digit_lo = hex_digit(b);
                digit_count++;
            end
        end
        byte_index++;
    endtask

    task automatic report_field(input string field, input int want, input int got);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    initial
    begin
        error_count = 0;
        pending     = 0;
        in_sentence = 0;
        restart_sentence();
    end

    always @(posedge clk)
    begin
        nsfc_pkg::result_t want;
        if (rst_n) begin
            // result beats first: a result never comes from the byte of the same edge
            if (m_tvalid && m_tready) begin
                if (sentence_reports_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                end
                else begin
                    want = sentence_reports_q.pop_front();
                    if (m_tdata[1:0] != want.sentence_type)
                        report_field("sentence_type", want.sentence_type, m_tdata[1:0]);
                    if (m_tdata[2] != want.checksum_ok)
                        report_field("checksum_ok", want.checksum_ok, m_tdata[2]);
                    if (m_tdata[9:3] != want.sentence_length)
                        report_field("sentence_length", want.sentence_length, m_tdata[9:3]);
                    if (m_tdata[15:10] != 6'd0)
                        report_field("padding", 0, m_tdata[15:10]);
                end
            end
            if (s_tvalid && s_tready)
                track_rx_byte(s_tdata);
            pending = sentence_reports_q.size();
        end
    end

endmodule

>>> tb/testbench.sv
// top of the nmea sentence filter checker testbench: clock, reset, byte stimulus, result
// back-pressure, watchdog and verdict; depends on nsfc_pkg, the block and sentence_result_monitor
module testbench;

    localparam int MAX_LEN        = 128;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_BYTES   = 450;

    typedef enum int {
        CK_GOOD,
        CK_WRONG,
        CK_BADHEX,
        CK_HIGH_ONLY,
        CK_NONE
    } checksum_form_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [1:0] sentence_type, [2] checksum_ok, [9:3] sentence_length

    int          error_count;
    int          pending;
    int          stall_cycles;
    int          bytes_sent;
    bit          hold_off;
    bit          quiet;
    logic [7:0]  frame_q [$];

    localparam logic [39:0] TEXT_GNRMC = "GNRMC";
    localparam logic [39:0] TEXT_GPGSA = "GPGSA";
    localparam logic [39:0] TEXT_GNGGA = "GNGGA";

    nmea_sentence_filter_checker #(
        .MAX_LEN (MAX_LEN)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sentence_result_monitor #(
        .MAX_LEN (MAX_LEN)
    ) u_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .pending     (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] name_letter(input int k, input int i);
        logic [39:0] word;
        case (k)
            0:       word = TEXT_GNRMC;
            1:       word = TEXT_GPGSA;
            default: word = TEXT_GNGGA;
        endcase
        return word[39 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 10)
            return 8'h30 + v;
        return 8'((lower ? 8'h61 : 8'h41) + v - 10);
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        if ($urandom_range(99) < 90) begin
            do
                c = 8'($urandom_range(32, 126));
            while (c == nsfc_pkg::CH_DOLLAR || c == nsfc_pkg::CH_STAR);
        end
        else begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == nsfc_pkg::CH_DOLLAR || c == nsfc_pkg::CH_CR);
        end
        return c;
    endfunction

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            frame_q.push_back(s[i]);
    endtask

    // one beat per byte, a short random gap in front unless quiet
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        while (frame_q.size() != 0)
            send_byte(frame_q.pop_front());
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic build_sentence(input int k, input int body_len, input checksum_form_t form);
        logic [7:0] x;
        bit         stop;
        bit         lower;
        int         i;
        lower = 1'($urandom_range(1));
        frame_q.push_back(nsfc_pkg::CH_DOLLAR);
        for (i = 0; i < nsfc_pkg::NAME_LEN; i++)
            frame_q.push_back(name_letter(k, i));
        for (i = 0; i < body_len; i++)
            frame_q.push_back(body_char());
        x    = 8'h00;
        stop = 0;
        for (i = 1; i < frame_q.size(); i++) begin
            if (frame_q[i] == nsfc_pkg::CH_STAR || frame_q[i] == nsfc_pkg::CH_NUL)
                stop = 1;
            if (!stop)
                x ^= frame_q[i];
        end
        if (form != CK_NONE)
            frame_q.push_back(nsfc_pkg::CH_STAR);
        case (form)
            CK_GOOD:
            begin
                frame_q.push_back(hex_char(x[7:4], lower));
                frame_q.push_back(hex_char(x[3:0], lower));
            end
            CK_WRONG:
            begin
                x ^= 8'($urandom_range(1, 255));
                frame_q.push_back(hex_char(x[7:4], lower));
                frame_q.push_back(hex_char(x[3:0], lower));
            end
            CK_BADHEX:
            begin
                frame_q.push_back(body_char());
                frame_q.push_back(hex_char(x[3:0], lower));
            end
            CK_HIGH_ONLY:
                frame_q.push_back(hex_char(x[7:4], lower));
            default:
                ;
        endcase
        if ($urandom_range(99) < 10)
            frame_q.push_back(body_char());
        frame_q.push_back(nsfc_pkg::CH_CR);
    endtask

    task automatic random_sentence();
        int             pick;
        int             body_len;
        int             i;
        int             slot;
        checksum_form_t form;
        pick     = $urandom_range(99);
        body_len = ($urandom_range(99) < 92) ? $urandom_range(0, 20) : $urandom_range(21, 120);
        slot     = $urandom_range(99);
        if (slot < 70)
            form = CK_GOOD;
        else if (slot < 80)
            form = CK_WRONG;
        else if (slot < 87)
            form = CK_BADHEX;
        else if (slot < 94)
            form = CK_HIGH_ONLY;
        else
            form = CK_NONE;
        if (pick < 72) begin
            build_sentence($urandom_range(2), body_len, form);
        end
        else if (pick < 82) begin
            // corrupt one letter of the name
            build_sentence($urandom_range(2), body_len, form);
            frame_q[$urandom_range(1, nsfc_pkg::NAME_LEN)] = 8'($urandom_range(0, 255));
        end
        else if (pick < 90) begin
            frame_q.push_back(nsfc_pkg::CH_DOLLAR);
            slot = $urandom_range(0, nsfc_pkg::NAME_LEN - 1);
            body_len = $urandom_range(2);
            for (i = 0; i < slot; i++)
                frame_q.push_back(name_letter(body_len, i));
            frame_q.push_back(nsfc_pkg::CH_CR);
        end
        else if (pick < 92) begin
            build_sentence($urandom_range(2), $urandom_range(116, 119), form);
        end
        else begin
            slot = $urandom_range(1, 8);
            for (i = 0; i < slot; i++)
                frame_q.push_back(8'($urandom_range(0, 255)));
        end
        send_frame();
    endtask

    // result side: random back-pressure, one long hold when asked
    initial
    begin
        forever begin
            @(negedge clk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 0;
                m_tready <= 1'b1;
            end
            else begin
                m_tready <= (quiet || $urandom_range(99) >= 16);
            end
        end
    end

    initial
    begin
        stall_cycles = 0;
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        m_tready   = 1'b0;
        hold_off   = 0;
        quiet      = 0;
        bytes_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bytes outside any sentence
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'h00);
        push_text("x\r");
        // every name, lower case hex digits, no star
        push_text("$GNRMC*55\r");
        push_text("$GPGSA\r");
        push_text("$GPGSA,*6e\r");
        push_text("$GNGGA");
        frame_q.push_back(8'hFF);
        push_text("*b7\r");
        // early carriage return and unknown name
        push_text("$GNR\r");
        push_text("$GPXSA,1*00\r");
        // zero byte before the star
        push_text("$GNGGA");
        frame_q.push_back(8'h00);
        push_text("*48\r");
        // bad hex digit, one missing digit that still matches, both missing
        push_text("$GNRMC*G5\r");
        push_text("$GNRMCz*3\r");
        push_text("$GNRMC*\r");
        // restart mid-name, extra byte after the digits
        push_text("$GNRM$GPGSA*42X\r");
        send_frame();
        // longest sentence, then one byte too long
        build_sentence(2, 117, CK_GOOD);
        build_sentence(0, 118, CK_GOOD);
        send_frame();
        drain_results();

        // long result hold while bytes keep coming
        hold_off = 1;
        for (n = 0; n < 12; n++) begin
            build_sentence($urandom_range(2), 0, CK_GOOD);
            send_frame();
        end
        drain_results();

        bytes_sent = 0;
        n = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            quiet = (n >= 30 && n < 45);
            random_sentence();
            if (n == 60)
                drain_results();
            n++;
        end
        quiet = 0;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
